/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Implication form of the above.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

`endif

/* hw/rtl/ucsd_pkg.sv */
package ucsd_pkg;

	localparam logic [1:0] ST_ORDINARY   = 2'd0;
	localparam logic [1:0] ST_TERMINATOR = 2'd1;
	localparam logic [1:0] ST_OVERRUN    = 2'd2;

	localparam int BYTE_BITS = 8;

	typedef struct packed {
		logic [BYTE_BITS-1:0] data_byte;
		logic                 new_record;
		logic [BYTE_BITS-1:0] end_code;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} queue_head_t;

endpackage

/* hw/rtl/unary_code_stream_decoder.sv */
// channel | direction | fields                           | handshake
// data    | in        | data_byte, new_record, end_code  | data_valid / data_stall
// code    | out       | code_value, status, last         | code_valid / code_stall
//
// The bit engine takes one bit of a word per cycle while the output is not stalled; a word
// ends early at the bit that ends the record, and one after the end ends at its first bit.
// Up to 8 codes per word, one per cycle while not stalled. A 2-entry queue sits between input
// and bit engine; a taken word is queued, loaded into the engine, and its codes registered.
// arst_n clears queue, run count, done flag and valids.
// code_stall with a code valid freezes the bit engine only; input keeps filling the queue until it is full.
module unary_code_stream_decoder #(
	parameter int CODE_MAX = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       new_record,
	input  logic [7:0] end_code,
	output logic       code_valid,
	input  logic       code_stall,
	output logic [7:0] code_value,
	output logic [1:0] status,
	output logic       last
);
	import ucsd_pkg::*;

	queue_head_t head;
	logic        q_pop;

	ucsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.new_record (new_record),
		.end_code   (end_code),
		.head       (head),
		.q_pop      (q_pop)
	);

	ucsd_back #(
		.CODE_MAX (CODE_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_pop      (q_pop),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_value (code_value),
		.status     (status),
		.last       (last)
	);

endmodule

/* hw/rtl/ucsd_front.sv */
module ucsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_stall,
	input  logic [7:0]         data_byte,
	input  logic               new_record,
	input  logic [7:0]         end_code,
	output ucsd_pkg::queue_head_t head,
	input  logic               q_pop
);
	import ucsd_pkg::*;

	item_t      mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      word_in;

	assign data_stall = (cnt_q == 2'd2);
	assign push       = data_valid && !data_stall;

	always_comb begin
		word_in.data_byte  = data_byte;
		word_in.new_record = new_record;
		word_in.end_code   = end_code;
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/ucsd_back.sv */
module ucsd_back #(
	parameter int CODE_MAX = 255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ucsd_pkg::queue_head_t head,
	output logic                  q_pop,
	output logic                  code_valid,
	input  logic                  code_stall,
	output logic [7:0]            code_value,
	output logic [1:0]            status,
	output logic                  last
);
	import ucsd_pkg::*;

	item_t      cur_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic [7:0] run_q;
	logic       done_q;
	logic       valid_q;
	logic [7:0] value_q;
	logic [1:0] status_q;
	logic       last_q;

	logic       out_free;
	logic       advance;
	logic       bit_v;
	logic       res_v;
	logic [1:0] res_status;
	logic [7:0] res_value;
	logic [7:0] run_nx;
	logic       done_nx;
	logic [7:0] rem;
	logic [2:0] nrem;
	logic       more;
	logic       finish;
	logic       load;

	assign out_free = !valid_q || !code_stall;
	assign advance  = busy_q && out_free;
	assign bit_v    = cur_q.data_byte[idx_q];

	always_comb begin
		res_v      = 1'b0;
		res_status = ST_ORDINARY;
		res_value  = 8'd0;
		run_nx     = run_q;
		done_nx    = done_q;
		if (!done_q) begin
			if (!bit_v) begin
				if ((run_q >= cur_q.end_code) || (32'(run_q) >= CODE_MAX)) begin
					res_v      = 1'b1;
					res_status = ST_OVERRUN;
					run_nx     = 8'd0;
					done_nx    = 1'b1;
				end else begin
					run_nx = run_q + 8'd1;
				end
			end else begin
				res_v  = 1'b1;
				run_nx = 8'd0;
				priority if (run_q > cur_q.end_code) begin
					res_status = ST_OVERRUN;
					done_nx    = 1'b1;
				end else if (run_q == cur_q.end_code) begin
					res_status = ST_TERMINATOR;
					res_value  = run_q;
					done_nx    = 1'b1;
				end else begin
					res_value = run_q;
				end
			end
		end
	end

	// another result follows in this word: a one bit ahead, or a zero run long enough to overrun
	assign rem    = (cur_q.data_byte >> idx_q) >> 1;
	assign nrem   = 3'd7 - idx_q;
	assign more   = (|rem) || (32'(nrem) > CODE_MAX) || ({5'd0, nrem} > cur_q.end_code);
	assign finish = done_nx || (idx_q == 3'd7);
	assign load   = head.valid && (!busy_q || (advance && finish));
	assign q_pop  = load;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head.item;
		end
		if (advance && res_v) begin
			value_q  <= res_value;
			status_q <= res_status;
			last_q   <= done_nx || !more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= 3'd0;
			run_q   <= 8'd0;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= 3'd0;
				if (head.item.new_record) begin
					run_q  <= 8'd0;
					done_q <= 1'b0;
				end else if (advance) begin
					run_q  <= run_nx;
					done_q <= done_nx;
				end
			end else if (advance) begin
				run_q  <= run_nx;
				done_q <= done_nx;
				idx_q  <= idx_q + 3'd1;
				if (finish) begin
					busy_q <= 1'b0;
				end
			end
			if (advance && res_v) begin
				valid_q <= 1'b1;
			end else if (!code_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign code_valid = valid_q;
	assign code_value = value_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

/* hw/rtl/ucsd_chk.sv */
`include "assert_macros.svh"

module ucsd_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       data_valid,
	input logic       data_stall,
	input logic [7:0] data_byte,
	input logic       new_record,
	input logic [7:0] end_code,
	input logic       code_valid,
	input logic       code_stall,
	input logic [7:0] code_value,
	input logic [1:0] status,
	input logic       last
);
	import ucsd_pkg::*;

	logic unused_in;
	assign unused_in = data_valid ^ data_stall ^ (^data_byte) ^ new_record ^ (^end_code);

	`ASSERT_CLK(a_hold, clk, arst_n, (code_valid && code_stall) |=> (code_valid && $stable(code_value) && $stable(status) && $stable(last)))
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, code_valid, (status == ST_ORDINARY || status == ST_TERMINATOR || status == ST_OVERRUN))
	`ASSERT_IMPLIES(a_overrun_zero, clk, arst_n, (code_valid && status == ST_OVERRUN), (code_value == 8'd0))
	`ASSERT_IMPLIES(a_end_is_last, clk, arst_n, (code_valid && status != ST_ORDINARY), last)

endmodule

bind unary_code_stream_decoder ucsd_chk u_chk (.*);
